// File: rtl/core/rbb_pkg.sv
// Package for the RGB 3x3 box blur: register indexes, controller states,
// command and status structs and the reciprocal table. No dependencies.
`default_nettype none

package rbb_pkg;

    localparam int CFG_W = 11;
    localparam int CH_W  = 8;
    localparam int POS_W = 10;
    localparam int SUM_W = 12;
    localparam int CNT_W = 4;
    localparam int RCP_W = 21;
    localparam int RCP_SHIFT = 20;
    localparam int PROD_W = SUM_W + RCP_W;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 11'd1024;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_WIN,
        ST_DRAIN,
        ST_MUL,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       rd_en;
        logic [1:0] win_row;
        logic [1:0] win_col;
        logic       emit_up;
        logic       emit_left;
        logic       mul;
        logic       load_out;
        logic       last;
    } rbb_cmd_t;

    typedef struct packed {
        logic [3:0] flags;
        logic       out_free;
    } rbb_status_t;

    // Reciprocals ceil(2^20 / n); exact for every sum up to 9 * 255.
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] r;
        begin
            unique case (n)
                4'd1:    r = 21'd1048576;
                4'd2:    r = 21'd524288;
                4'd3:    r = 21'd349526;
                4'd4:    r = 21'd262144;
                4'd5:    r = 21'd209716;
                4'd6:    r = 21'd174763;
                4'd7:    r = 21'd149797;
                4'd8:    r = 21'd131072;
                4'd9:    r = 21'd116509;
                default: r = 21'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rbb_pix_if.sv
// Input pixel channel: valid, ready and the three color channels.
// Depends on rbb_pkg for the channel width.
`default_nettype none

interface rbb_pix_if
    import rbb_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/rbb_res_if.sv
// Result channel: valid, ready, blurred colors, position and run marker.
// Depends on rbb_pkg for field widths.
`default_nettype none

interface rbb_res_if
    import rbb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             last_of_run;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_col, output out_row, output last_of_run, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input out_col, input out_row, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rbb_ctrl.sv
// Controller of the box blur: walks each pending result through a 3x3 window
// scan, the divide step and the output load. Depends on rbb_pkg.
`default_nettype none

module rbb_ctrl
    import rbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_ready,
    input  wire rbb_status_t status,
    output rbb_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic [3:0]  pend_reg, pend_next;
    logic [1:0]  wr_reg, wr_next;
    logic [1:0]  wc_reg, wc_next;
    logic        up_reg, up_next;
    logic        left_reg, left_next;
    logic        last_reg, last_next;
    logic [3:0]  avail;
    logic [3:0]  rest;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            wr_reg    <= '0;
            wc_reg    <= '0;
            up_reg    <= 1'b0;
            left_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            wr_reg    <= wr_next;
            wc_reg    <= wc_next;
            up_reg    <= up_next;
            left_reg  <= left_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        wr_next    = wr_reg;
        wc_next    = wc_reg;
        up_next    = up_reg;
        left_next  = left_reg;
        last_next  = last_reg;
        avail      = pend_reg & status.flags;
        rest       = avail;
        pix_ready  = 1'b0;

        cmd           = '0;
        cmd.win_row   = wr_reg;
        cmd.win_col   = wc_reg;
        cmd.emit_up   = up_reg;
        cmd.emit_left = left_reg;
        cmd.last      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix_valid)
                begin
                    cmd.accept = 1'b1;
                    pend_next  = 4'hF;
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                cmd.clear = 1'b1;
                wr_next   = '0;
                wc_next   = '0;
                priority if (avail[0])
                begin
                    rest[0]   = 1'b0;
                    up_next   = 1'b1;
                    left_next = 1'b1;
                end
                else if (avail[1])
                begin
                    rest[1]   = 1'b0;
                    up_next   = 1'b1;
                    left_next = 1'b0;
                end
                else if (avail[2])
                begin
                    rest[2]   = 1'b0;
                    up_next   = 1'b0;
                    left_next = 1'b1;
                end
                else if (avail[3])
                begin
                    rest[3]   = 1'b0;
                    up_next   = 1'b0;
                    left_next = 1'b0;
                end
                else
                begin
                    rest = avail;
                end
                pend_next  = rest;
                last_next  = (rest == 4'h0);
                state_next = (avail == 4'h0) ? ST_IDLE : ST_WIN;
            end
            ST_WIN:
            begin
                cmd.rd_en = 1'b1;
                if (wc_reg == 2'd2)
                begin
                    wc_next = '0;
                    if (wr_reg == 2'd2)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        wr_next = wr_reg + 2'd1;
                    end
                end
                else
                begin
                    wc_next = wc_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_SEL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rbb_datapath.sv
// Datapath of the box blur: configuration, frame counters, three-row line
// memory, window accumulators, reciprocal divide and output register.
// Depends on rbb_pkg and the two channel interfaces.
`default_nettype none

module rbb_datapath
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wen,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    rbb_pix_if.sink               pix,
    rbb_res_if.source             blur,
    input  wire rbb_cmd_t         cmd,
    output rbb_status_t           status
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(3 * MAX_WIDTH);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int OCW = (CW > POS_W) ? CW : POS_W;
    localparam int ORW = (RW > POS_W) ? RW : POS_W;

    function automatic logic [AW-1:0] row_base(input logic [1:0] s);
        logic [AW-1:0] b;
        begin
            unique case (s)
                2'd1:    b = AW'(MAX_WIDTH);
                2'd2:    b = AW'(2 * MAX_WIDTH);
                default: b = '0;
            endcase
            return b;
        end
    endfunction

    logic [CFG_W-1:0] fw_reg, fh_reg;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;

    logic [CW-1:0] col_reg, cur_c_reg, c_in;
    logic [RW-1:0] row_reg, cur_r_reg, r_in;
    logic [1:0]    slot_reg, cur_s_reg, s_in;

    logic [3*CH_W-1:0] mem [DEPTH];
    logic [3*CH_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     wr_addr, rd_addr;

    logic          row_ahead, col_ahead, row_ok, col_ok;
    logic [1:0]    rback, cback, rd_slot;
    logic [CW-1:0] rd_col;

    logic [SUM_W-1:0]  sum_r_reg, sum_g_reg, sum_b_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [RCP_W-1:0]  rcp;

    logic             out_valid_reg;
    logic [CH_W-1:0]  out_r_reg, out_g_reg, out_b_reg;
    logic [POS_W-1:0] out_col_reg, out_row_reg;
    logic             out_last_reg;
    logic [OCW-1:0]   col_ext;
    logic [ORW-1:0]   row_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_SIZE_RESET;
            fh_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (int'(fw_reg) > MAX_WIDTH)
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(fw_reg);
        end
        if (fh_reg == '0)
        begin
            h_eff = RW'(1);
        end
        else if (int'(fh_reg) > MAX_HEIGHT)
        begin
            h_eff = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = RW'(fh_reg);
        end
    end

    assign c_in = (col_reg >= w_eff) ? '0 : col_reg;
    assign r_in = (row_reg >= h_eff) ? '0 : row_reg;
    assign s_in = (row_reg >= h_eff) ? 2'd0 : slot_reg;
    assign wr_addr = row_base(s_in) + AW'(c_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if ({1'b0, c_in} + 1'b1 >= {1'b0, w_eff})
            begin
                col_reg <= '0;
                if ({1'b0, r_in} + 1'b1 >= {1'b0, h_eff})
                begin
                    row_reg  <= '0;
                    slot_reg <= 2'd0;
                end
                else
                begin
                    row_reg  <= r_in + 1'b1;
                    slot_reg <= (s_in == 2'd2) ? 2'd0 : s_in + 2'd1;
                end
            end
            else
            begin
                col_reg <= c_in + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_c_reg <= c_in;
            cur_r_reg <= r_in;
            cur_s_reg <= s_in;
        end
    end

    assign status.flags[0] = (cur_r_reg != '0) && (cur_c_reg != '0);
    assign status.flags[1] = (cur_r_reg != '0) && (cur_c_reg == w_eff - 1'b1);
    assign status.flags[2] = (cur_r_reg == h_eff - 1'b1) && (cur_c_reg != '0);
    assign status.flags[3] = (cur_r_reg == h_eff - 1'b1) && (cur_c_reg == w_eff - 1'b1);
    assign status.out_free = !out_valid_reg || blur.ready;

    // Window position relative to the current input: back rows and columns.
    always_comb
    begin
        row_ahead = (cmd.win_row == 2'd2) && !cmd.emit_up;
        col_ahead = (cmd.win_col == 2'd2) && !cmd.emit_left;
        rback     = 2'd1 + {1'b0, cmd.emit_up} - cmd.win_row;
        cback     = 2'd1 + {1'b0, cmd.emit_left} - cmd.win_col;
        row_ok    = !row_ahead && (int'(cur_r_reg) >= int'(rback));
        col_ok    = !col_ahead && (int'(cur_c_reg) >= int'(cback));
        rd_col    = cur_c_reg - CW'(cback);
        unique case (rback)
            2'd1:    rd_slot = (cur_s_reg == 2'd0) ? 2'd2 : cur_s_reg - 2'd1;
            2'd2:    rd_slot = (cur_s_reg == 2'd2) ? 2'd0 : cur_s_reg + 2'd1;
            default: rd_slot = cur_s_reg;
        endcase
        rd_addr = row_base(rd_slot) + AW'(rd_col);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem[wr_addr] <= {pix.in_blue, pix.in_green, pix.in_red};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en && row_ok && col_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_r_reg <= sum_r_reg + SUM_W'(rd_data_reg[CH_W-1:0]);
            sum_g_reg <= sum_g_reg + SUM_W'(rd_data_reg[2*CH_W-1:CH_W]);
            sum_b_reg <= sum_b_reg + SUM_W'(rd_data_reg[3*CH_W-1:2*CH_W]);
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    assign rcp = recip(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_r_reg <= PROD_W'(sum_r_reg) * PROD_W'(rcp);
            prod_g_reg <= PROD_W'(sum_g_reg) * PROD_W'(rcp);
            prod_b_reg <= PROD_W'(sum_b_reg) * PROD_W'(rcp);
        end
    end

    assign col_ext = OCW'(cur_c_reg - CW'(cmd.emit_left));
    assign row_ext = ORW'(cur_r_reg - RW'(cmd.emit_up));

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_r_reg    <= prod_r_reg[RCP_SHIFT+CH_W-1:RCP_SHIFT];
            out_g_reg    <= prod_g_reg[RCP_SHIFT+CH_W-1:RCP_SHIFT];
            out_b_reg    <= prod_b_reg[RCP_SHIFT+CH_W-1:RCP_SHIFT];
            out_col_reg  <= col_ext[POS_W-1:0];
            out_row_reg  <= row_ext[POS_W-1:0];
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (blur.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign blur.valid       = out_valid_reg;
    assign blur.out_red     = out_r_reg;
    assign blur.out_green   = out_g_reg;
    assign blur.out_blue    = out_b_reg;
    assign blur.out_col     = out_col_reg;
    assign blur.out_row     = out_row_reg;
    assign blur.last_of_run = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/rgb_box_blur_3x3.sv
// Top level of the RGB 3x3 box blur: controller plus datapath.
// Depends on rbb_pkg, rbb_pix_if, rbb_res_if, rbb_ctrl and rbb_datapath.
//
//   channel | direction | payload
//   --------+-----------+-----------------------------------------------
//   pix     | in        | in_red, in_green, in_blue
//   blur    | out       | out_red, out_green, out_blue, out_col, out_row,
//           |           | last_of_run
//   cfg     | in        | frame_width (index 0), frame_height (index 1)
//
// An item releases 0 to 4 results; each result takes a window scan of nine
// reads through the one read port of the line memory, a drain, a divide and a load.
// The reset is asynchronous and needs no clearing pass of the line memory.
// A stalled result stalls the controller in its output state only.
`default_nettype none

module rgb_box_blur_3x3
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wen,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    rbb_pix_if.sink               pix,
    rbb_res_if.source             blur
);

    rbb_cmd_t    cmd;
    rbb_status_t status;

    rbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix.valid),
        .pix_ready (pix.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rbb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .blur      (blur),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: rtl/core/rbb_checker.sv
// Port-level checks of the box blur, attached to the top level by bind.
// Depends on rbb_pkg for field widths.
`default_nettype none

module rbb_checker
    import rbb_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             pix_valid,
    input wire logic             pix_ready,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic [POS_W-1:0] res_col,
    input wire logic [POS_W-1:0] res_row
);

    logic pix_acc;

    assign pix_acc = pix_valid && pix_ready;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("Result item dropped while stalled.");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_col) && $stable(res_row))
        else $error("Result position changed while stalled.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> !pix_ready)
        else $error("Input taken while the previous item is still in work.");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> !$rose(res_valid))
        else $error("Result appeared before its window was read.");

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .res_valid (blur.valid),
    .res_ready (blur.ready),
    .res_col   (blur.out_col),
    .res_row   (blur.out_row)
);

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for rgb_box_blur_3x3: streams whole and partial frames of pixels under several
// frame sizes and checks every blurred result against its own line-store predictor.
// Depends on rbb_pkg, rbb_pix_if, rbb_res_if and the block itself.
`default_nettype none

module tb_top;
    import rbb_pkg::*;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 60;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } blur_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wen;
    logic [0:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    rbb_pix_if pix_ch ();
    rbb_res_if blur_ch ();

    rgb_box_blur_3x3 #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch.sink),
        .blur      (blur_ch.source)
    );

    logic [23:0]      pixel_q [$];
    blur_t            blurred_q [$];
    logic [23:0]      line_mem [0:3*MAXW-1];
    int               col_cnt;
    int               row_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int               mismatches;
    int               idle_cycles;
    logic             pix_fire;
    logic             no_stall;
    int               burst_left;
    int               gap_left;
    int               stall_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic blur_t window_mean(int col, int row, int w, int h);
        blur_t res;
        int    sum_r;
        int    sum_g;
        int    sum_b;
        int    cnt;
        logic [23:0] px;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt = 0;
        for (int rr = (row > 0 ? row - 1 : 0); rr <= (row + 1 < h ? row + 1 : row); rr++)
        begin
            for (int cc = (col > 0 ? col - 1 : 0); cc <= (col + 1 < w ? col + 1 : col); cc++)
            begin
                px = line_mem[(rr % 3) * MAXW + cc];
                sum_r += px[7:0];
                sum_g += px[15:8];
                sum_b += px[23:16];
                cnt++;
            end
        end
        res.red   = CH_W'(sum_r / cnt);
        res.green = CH_W'(sum_g / cnt);
        res.blue  = CH_W'(sum_b / cnt);
        res.col   = POS_W'(col);
        res.row   = POS_W'(row);
        res.last  = 1'b0;
        return res;
    endfunction

    function automatic void predict_blur(logic [23:0] px);
        blur_t res [4];
        int    n;
        int    w;
        int    h;
        int    c;
        int    r;
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        if (col_cnt >= w)
            col_cnt = 0;
        if (row_cnt >= h)
            row_cnt = 0;
        c = col_cnt;
        r = row_cnt;
        line_mem[(r % 3) * MAXW + c] = px;
        n = 0;
        if (r >= 1 && c >= 1)
            res[n++] = window_mean(c - 1, r - 1, w, h);
        if (r >= 1 && c == w - 1)
            res[n++] = window_mean(c, r - 1, w, h);
        if (r == h - 1 && c >= 1)
            res[n++] = window_mean(c - 1, r, w, h);
        if (r == h - 1 && c == w - 1)
            res[n++] = window_mean(c, r, w, h);
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            blurred_q.push_back(res[i]);
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_cnt = c + 1;
    endfunction

    // Monitor: prediction on accepted pixels, comparison on accepted results.
    always @(posedge clk)
    begin
        blur_t got;
        blur_t want;
        pix_fire <= pix_ch.valid && pix_ch.ready;
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
                predict_blur({pix_ch.in_blue, pix_ch.in_green, pix_ch.in_red});
            if (blur_ch.valid && blur_ch.ready)
            begin
                got = {blur_ch.out_red, blur_ch.out_green, blur_ch.out_blue,
                       blur_ch.out_col, blur_ch.out_row, blur_ch.last_of_run};
                if (blurred_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: col %0d row %0d", got.col, got.row);
                end
                else
                begin
                    want = blurred_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected rgb %h %h %h col %0d row %0d",
                                      " last %b, got rgb %h %h %h col %0d row %0d last %b"},
                                     want.red, want.green, want.blue, want.col, want.row,
                                     want.last, got.red, got.green, got.blue, got.col,
                                     got.row, got.last);
                    end
                end
            end
            if ((pix_ch.valid && pix_ch.ready) || (blur_ch.valid && blur_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Pixel driver: bursts of items with random gaps.
    always @(negedge clk)
    begin
        logic        drive;
        logic [23:0] px;
        drive = 1'b0;
        px = {pix_ch.in_blue, pix_ch.in_green, pix_ch.in_red};
        if (rst_n)
        begin
            if (pix_ch.valid && !pix_fire)
                drive = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            else if (pixel_q.size() > 0)
            begin
                px = pixel_q.pop_front();
                drive = 1'b1;
                burst_left--;
            end
        end
        pix_ch.valid    <= drive;
        pix_ch.in_red   <= px[7:0];
        pix_ch.in_green <= px[15:8];
        pix_ch.in_blue  <= px[23:16];
    end

    // Result receiver: stalls of random length; none begins while no_stall is set.
    always @(negedge clk)
    begin
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0)
        begin
            rdy = 1'b0;
            stall_left--;
        end
        else if (!no_stall && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            rdy = 1'b0;
        end
        blur_ch.ready <= rdy;
    end

    task automatic wait_drained();
        while (pixel_q.size() != 0 || pix_ch.valid || blurred_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_frame(int w, int h);
        wait_drained();
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = CFG_W'(w);
        @(negedge clk);
        cfg_index = REG_FRAME_HEIGHT;
        cfg_data  = CFG_W'(h);
        @(negedge clk);
        cfg_wen   = 1'b0;
        width_reg  = CFG_W'(w);
        height_reg = CFG_W'(h);
    endtask

    task automatic push_random_frames(int frames, ref int sent);
        int n;
        n = frames * clamp_size(width_reg, MAXW) * clamp_size(height_reg, MAXH);
        for (int i = 0; i < n; i++)
            pixel_q.push_back(24'($urandom));
        sent += n;
    endtask

    initial
    begin
        int sent;
        rst_n      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_index  = REG_FRAME_WIDTH;
        cfg_data   = '0;
        pix_ch.valid    = 1'b0;
        pix_ch.in_red   = '0;
        pix_ch.in_green = '0;
        pix_ch.in_blue  = '0;
        blur_ch.ready   = 1'b0;
        pix_fire   = 1'b0;
        no_stall   = 1'b0;
        burst_left = 0;
        gap_left   = 0;
        stall_left = 0;
        col_cnt    = 0;
        row_cnt    = 0;
        width_reg  = FRAME_SIZE_RESET;
        height_reg = FRAME_SIZE_RESET;
        mismatches = 0;
        idle_cycles = 0;
        sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_frame(3, 3);
        pixel_q.push_back(24'h000000);
        pixel_q.push_back(24'hFFFFFF);
        pixel_q.push_back(24'h00FF00);
        pixel_q.push_back(24'hFF00FF);
        pixel_q.push_back(24'hAA55FF);
        pixel_q.push_back(24'h55AA00);
        pixel_q.push_back(24'h0000FF);
        pixel_q.push_back(24'hFFFFFE);
        pixel_q.push_back(24'h010101);
        sent += 9;
        set_frame(4, 4);
        for (int i = 0; i < 16; i++)
            pixel_q.push_back(24'hFFFFFF);
        sent += 16;

        set_frame(0, 0);
        push_random_frames(3, sent);
        set_frame(1, 1);
        push_random_frames(2, sent);
        set_frame(2, 2);
        push_random_frames(2, sent);
        // Midway through a frame the sender waits until all results are out.
        set_frame(5, 4);
        push_random_frames(1, sent);
        for (int i = 0; i < 7; i++)
            pixel_q.push_back(24'($urandom));
        while (pixel_q.size() != 0 || pix_ch.valid || blurred_q.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 13; i++)
            pixel_q.push_back(24'($urandom));
        sent += 20;
        // Oversized settings with partial frames; the next frame restarts at the origin.
        no_stall = 1'b1;
        set_frame(2047, 1);
        for (int i = 0; i < 40; i++)
            pixel_q.push_back(24'($urandom));
        sent += 40;
        no_stall = 1'b0;
        set_frame(1, 2047);
        for (int i = 0; i < 40; i++)
            pixel_q.push_back(24'($urandom));
        sent += 40;
        while (sent < 330)
        begin
            no_stall = ($urandom_range(0, 4) == 0);
            set_frame($urandom_range(1, 12), $urandom_range(1, 8));
            push_random_frames(1, sent);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && blurred_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
